/* hw/rtl/cordic_unified_q2_14_unit_assert.svh */
// ----------------------------------------------------------------------------
// CORDIC unit assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CORDIC_UNIFIED_Q2_14_UNIT_ASSERT_SVH
`define CORDIC_UNIFIED_Q2_14_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// property checked while out of reset
`define CUQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every edge, reset included
`define CUQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CUQ_ASSERT(lbl, clk, rstn, prop, msg)
`define CUQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* hw/rtl/cuq_pkg.sv */
// ----------------------------------------------------------------------------
// CORDIC unit package
// Mode codes, register indexes, angle tables and the hyperbolic schedule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cuq_pkg;

  localparam int DATA_W  = 16;
  localparam int TAB_LEN = 14;
  localparam int HYP_LEN = 15;

  // configuration register indexes
  localparam logic REG_ROT_VEC = 1'b0;
  localparam logic REG_COORD   = 1'b1;

  // coordinate system codes (code 3 runs as circular)
  localparam logic [1:0] CS_CIRC = 2'd0;
  localparam logic [1:0] CS_LIN  = 2'd1;
  localparam logic [1:0] CS_HYP  = 2'd2;

  typedef logic signed [DATA_W-1:0] word_t;

  // per-item mode bits that travel down the pipe
  typedef struct packed {
    logic vec;   // steer by sign of y
    logic hyp;
    logic lin;
  } mode_t;

  // atan(2^-i), Q2.14 truncated
  localparam word_t CIRC_TAB [TAB_LEN] = '{
    16'sd12867, 16'sd7596, 16'sd4013, 16'sd2037, 16'sd1022, 16'sd511, 16'sd255,
    16'sd127, 16'sd63, 16'sd31, 16'sd15, 16'sd7, 16'sd3, 16'sd1
  };

  // 2^-i, Q2.14; the smallest entry is kept as given
  localparam word_t LIN_TAB [TAB_LEN] = '{
    16'sd16384, 16'sd8192, 16'sd4096, 16'sd2048, 16'sd1024, 16'sd512, 16'sd256,
    16'sd128, 16'sd64, 16'sd32, 16'sd16, 16'sd8, 16'sd4, 16'sd2
  };

  // atanh(2^-i), Q2.14 truncated; entry 0 never used
  localparam word_t HYP_TAB [TAB_LEN] = '{
    16'sd0, 16'sd8999, 16'sd4184, 16'sd2058, 16'sd1025, 16'sd512, 16'sd256,
    16'sd128, 16'sd64, 16'sd32, 16'sd16, 16'sd8, 16'sd4, 16'sd2
  };

  // hyperbolic shift schedule, shifts 4 and 13 repeated
  localparam int HYP_SCHED [HYP_LEN] = '{
    1, 2, 3, 4, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 13
  };

endpackage

`default_nettype wire

/* hw/rtl/cordic_unified_q2_14_unit.sv */
// ----------------------------------------------------------------------------
// Unified Q2.14 CORDIC unit
// Circular, linear and hyperbolic CORDIC in rotation or vectoring mode,
// one micro-rotation per pipeline stage.
// ----------------------------------------------------------------------------
// A triple is taken on any edge with start high (busy is always low), one per
// clock with no gaps. The result passes through the unrolled chain of
// ITERATIONS+1 micro-rotation stages, one registered shift-add per stage, and
// leaves the last stage for one cycle with out_valid high. Circular and linear
// runs use the first ITERATIONS stages and pass through the last; hyperbolic
// runs use all of them. The receiver cannot stall, so results must be taken as
// they come. Mode is latched per item at the input; change configuration only
// once the pipe has drained.
`timescale 1ns / 1ps
`default_nettype none

`include "cordic_unified_q2_14_unit_assert.svh"

module cordic_unified_q2_14_unit #(
  parameter int ITERATIONS = 14
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               start,
  output      logic               busy,
  input  wire logic signed [15:0] in_x_start,
  input  wire logic signed [15:0] in_y_start,
  input  wire logic signed [15:0] in_z_start,
  // result channel
  output      logic               out_valid,
  output      logic signed [15:0] out_x_final,
  output      logic signed [15:0] out_y_final,
  output      logic signed [15:0] out_z_final,
  // configuration port
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [1:0]         cfg_wdata
);

  localparam int STAGES = ITERATIONS + 1;
  localparam int LAST   = STAGES - 1;

  // configuration registers
  logic       rot_vec_r;
  logic [1:0] coord_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_vec_r <= 1'b0;
      coord_r   <= cuq_pkg::CS_CIRC;
    end else if (cfg_we) begin
      if (cfg_index == cuq_pkg::REG_ROT_VEC) begin
        rot_vec_r <= cfg_wdata[0];
      end
      if (cfg_index == cuq_pkg::REG_COORD) begin
        coord_r <= cfg_wdata;
      end
    end
  end

  // no back-pressure on the input
  assign busy = 1'b0;

  // mode of an entering item
  cuq_pkg::mode_t in_mode;
  always_comb begin
    in_mode.vec = rot_vec_r;
    in_mode.hyp = (coord_r == cuq_pkg::CS_HYP);
    in_mode.lin = (coord_r == cuq_pkg::CS_LIN);
  end

  // stage registers and their next values
  logic           vld_r   [STAGES];
  logic           vld_nxt [STAGES];
  cuq_pkg::word_t x_r     [STAGES];
  cuq_pkg::word_t y_r     [STAGES];
  cuq_pkg::word_t z_r     [STAGES];
  cuq_pkg::word_t x_nxt   [STAGES];
  cuq_pkg::word_t y_nxt   [STAGES];
  cuq_pkg::word_t z_nxt   [STAGES];
  cuq_pkg::mode_t mode_r  [STAGES];
  cuq_pkg::mode_t mode_nxt[STAGES];

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    // shift and angle for this stage in each mode
    localparam int  SH_CL  = (j < cuq_pkg::TAB_LEN) ? j : cuq_pkg::TAB_LEN - 1;
    localparam int  SH_HY  = cuq_pkg::HYP_SCHED[j];
    localparam logic ACT_CL = (j < ITERATIONS);
    localparam cuq_pkg::word_t ANG_C = cuq_pkg::CIRC_TAB[SH_CL];
    localparam cuq_pkg::word_t ANG_L = cuq_pkg::LIN_TAB[SH_CL];
    localparam cuq_pkg::word_t ANG_H = cuq_pkg::HYP_TAB[SH_HY];

    logic           vi;
    cuq_pkg::mode_t mi;
    cuq_pkg::word_t xi, yi, zi;
    cuq_pkg::word_t dx, ys, dy, ang, xo, yo, zo;
    logic [3:0]     sh;
    logic           act, minus;

    // stage operands
    if (j == 0) begin : g_head
      assign vi = start & ~busy;
      assign mi = in_mode;
      assign xi = in_x_start;
      assign yi = in_y_start;
      assign zi = in_z_start;
    end else begin : g_body
      assign vi = vld_r[j-1];
      assign mi = mode_r[j-1];
      assign xi = x_r[j-1];
      assign yi = y_r[j-1];
      assign zi = z_r[j-1];
    end

    // one micro-rotation, or pass-through when this stage is unused
    always_comb begin
      act   = mi.hyp | ACT_CL;
      sh    = mi.hyp ? 4'(SH_HY) : 4'(SH_CL);
      ang   = mi.hyp ? ANG_H : (mi.lin ? ANG_L : ANG_C);
      minus = mi.vec ? yi[15] : ~zi[15];
      dx    = xi >>> sh;
      ys    = yi >>> sh;
      if (mi.hyp) begin
        dy = -ys;
      end else if (mi.lin) begin
        dy = '0;
      end else begin
        dy = ys;
      end
      if (!act) begin
        xo = xi;
        yo = yi;
        zo = zi;
      end else if (minus) begin
        xo = xi - dy;
        yo = yi + dx;
        zo = zi - ang;
      end else begin
        xo = xi + dy;
        yo = yi - dx;
        zo = zi + ang;
      end
    end

    assign vld_nxt[j]  = vi;
    assign mode_nxt[j] = mi;
    assign x_nxt[j]    = xo;
    assign y_nxt[j]    = yo;
    assign z_nxt[j]    = zo;
  end

  // valid bits are control; payload needs no reset
  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_nxt[k];
      end
      mode_r[k] <= mode_nxt[k];
      x_r[k]    <= x_nxt[k];
      y_r[k]    <= y_nxt[k];
      z_r[k]    <= z_nxt[k];
    end
  end

  // result strobe straight from the last stage
  assign out_valid   = vld_r[LAST];
  assign out_x_final = x_r[LAST];
  assign out_y_final = y_r[LAST];
  assign out_z_final = z_r[LAST];

  // checks
  `CUQ_ASSERT(a_latency, clk, rst_n,
              (start && !busy) |-> ##STAGES out_valid,
              "transfer lost in pipe")
  `CUQ_ASSERT(a_no_phantom, clk, rst_n,
              out_valid |-> $past(start && !busy, STAGES),
              "result without transfer")
  `CUQ_ASSERT(a_linear_x, clk, rst_n,
              (out_valid && mode_r[LAST].lin) |->
                (out_x_final == $past(in_x_start, STAGES)),
              "linear mode changed x")
  `CUQ_ASSERT_ALWAYS(a_reset_flush, clk, !rst_n |=> !out_valid, "valid survived reset")

endmodule

`default_nettype wire
